/* rtl/pcas_pkg.sv */
// pcas_pkg: shared types and constants of the configuration access splitter
// request, result and queued job words, status codes, register indexes
// no dependencies
`default_nettype none

package pcas_pkg;

    // status codes of a result word
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNREACH   = 2'd1,
        ST_NO_BRIDGE = 2'd2
    } t_status;

    // bridge kinds
    localparam logic [1:0] BRIDGE_NONE      = 2'd0;
    localparam logic [1:0] BRIDGE_FOUR_SLOT = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_BRIDGE_KIND = 2'd0;
    localparam logic [1:0] CFG_BUS0_BASE   = 2'd1;
    localparam logic [1:0] CFG_BUSN_BASE   = 2'd2;

    localparam logic [31:0] SLOT_STRIDE  = 32'h0001_0000;
    localparam logic [31:0] SLOT4_WINDOW = 32'h0003_0000;
    localparam logic [7:0]  LAST_BUS     = 8'd15;
    localparam logic [4:0]  LAST_SLOT    = 5'd3;
    localparam logic [4:0]  SLOT4        = 5'd4;

    // running offset holds up to 255 + 127
    localparam int OFF_W = 9;

    typedef struct packed {
        logic       command;
        logic [7:0] bus;
        logic [4:0] device;
        logic [2:0] function_req;
        logic [7:0] start_offset;
        logic [6:0] byte_count;
    } t_req;

    typedef struct packed {
        logic [31:0] access_address;
        logic [2:0]  access_size;
        logic        is_write;
        logic [1:0]  status;
        logic        last;
    } t_rsp;

    // classified request waiting for the sequencer
    typedef struct packed {
        logic [31:0]      base;
        logic             add_off;
        t_status          status;
        logic             is_write;
        logic [OFF_W-1:0] off;
        logic [6:0]       left;
    } t_job;

    // job queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

/* rtl/pcas_front.sv */
// pcas_front: configuration registers and request classification
// depends on pcas_pkg
`default_nettype none

module pcas_front
    import pcas_pkg::*;
#(
    parameter int MAX_BYTES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        i_take,
    input  wire t_req        i_req,
    output logic             o_job_we,
    output t_job             o_job
);

    localparam int CLAMP = (MAX_BYTES > 127) ? 127 : MAX_BYTES;
    localparam logic [6:0] CLAMP_COUNT = 7'(CLAMP);

    logic [1:0]  r_bridge_kind;
    logic [31:0] r_bus0_base;
    logic [31:0] r_busn_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bridge_kind <= BRIDGE_NONE;
            r_bus0_base   <= '0;
            r_busn_base   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BRIDGE_KIND: r_bridge_kind <= i_cfg_wdata[1:0];
                CFG_BUS0_BASE:   r_bus0_base   <= i_cfg_wdata;
                CFG_BUSN_BASE:   r_busn_base   <= i_cfg_wdata;
                default:         ;
            endcase
        end
    end

    logic [6:0]  count;
    logic [31:0] fn_part;

    always_comb begin
        count   = (i_req.byte_count > CLAMP_COUNT) ? CLAMP_COUNT : i_req.byte_count;
        fn_part = {21'b0, i_req.function_req, 8'b0};

        o_job.base     = '0;
        o_job.add_off  = 1'b0;
        o_job.status   = ST_OK;
        o_job.is_write = i_req.command;
        o_job.off      = {1'b0, i_req.start_offset};
        o_job.left     = count;

        if (r_bridge_kind == BRIDGE_NONE) begin
            o_job.status = ST_NO_BRIDGE;
        end else if (i_req.bus == 8'd0) begin
            if (r_bus0_base == 32'd0) begin
                o_job.status = ST_UNREACH;
            end else if (i_req.device <= LAST_SLOT) begin
                o_job.base    = r_bus0_base + (SLOT_STRIDE << i_req.device[1:0]) + fn_part;
                o_job.add_off = 1'b1;
            end else if (i_req.device == SLOT4 && r_bridge_kind == BRIDGE_FOUR_SLOT) begin
                o_job.base    = r_bus0_base + SLOT4_WINDOW + fn_part;
                o_job.add_off = 1'b1;
            end else begin
                // no slot selected: bare window base
                o_job.base = r_bus0_base;
            end
        end else if (r_busn_base == 32'd0 || i_req.bus > LAST_BUS) begin
            o_job.status = ST_UNREACH;
        end else begin
            o_job.base    = r_busn_base
                          + {12'b0, i_req.bus[3:0], i_req.device, i_req.function_req, 8'b0};
            o_job.add_off = 1'b1;
        end

        // zero byte count with a bridge yields nothing
        o_job_we = i_take && (r_bridge_kind == BRIDGE_NONE || count != 7'd0);
    end

endmodule

`default_nettype wire

/* rtl/pcas_fifo.sv */
// pcas_fifo: two-entry job queue between classifier and sequencer
// depends on pcas_pkg
`default_nettype none

module pcas_fifo
    import pcas_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_we,
    input  wire t_job i_job,
    input  wire logic i_re,
    output t_job      o_job,
    output t_q_stat   o_stat
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic do_wr;
    logic do_rd;

    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);
    assign do_wr = i_we && !o_stat.full;
    assign do_rd = i_re && !o_stat.empty;
    assign o_job = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_rd) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/pcas_back.sv */
// pcas_back: access sequencer, cuts a job into 1/2/4 byte accesses
// depends on pcas_pkg; result word held in an output register
`default_nettype none

module pcas_back
    import pcas_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_job i_job,
    input  wire logic i_q_empty,
    output logic      o_q_pop,
    output logic      o_empty,
    input  wire logic i_pop,
    output t_rsp      o_rsp
);

    logic r_busy;
    t_job r_job;
    logic r_out_valid;
    t_rsp r_out;

    t_job       cur;
    t_job       n_job;
    logic       out_free;
    logic       advance;
    logic [2:0] len;
    logic [6:0] rem;
    t_rsp       res;

    always_comb begin
        cur      = r_busy ? r_job : i_job;
        out_free = !r_out_valid || i_pop;
        advance  = (r_busy || !i_q_empty) && out_free;
        o_q_pop  = advance && !r_busy;

        if (cur.status == ST_NO_BRIDGE) begin
            len = 3'd0;
        end else if (cur.off[0]) begin
            len = 3'd1;
        end else if (cur.left == 7'd3) begin
            len = 3'd2;
        end else if (cur.left > 7'd4) begin
            len = 3'd4;
        end else begin
            len = cur.left[2:0];
        end
        rem = (cur.status == ST_NO_BRIDGE) ? 7'd0 : cur.left - {4'b0, len};

        n_job      = cur;
        n_job.off  = cur.off + {{(OFF_W-3){1'b0}}, len};
        n_job.left = rem;

        res.access_size = len;
        res.is_write    = cur.is_write;
        res.status      = cur.status;
        res.last        = (rem == 7'd0);
        if (cur.status != ST_OK) begin
            res.access_address = '0;
        end else if (cur.add_off) begin
            res.access_address = cur.base + {{(32-OFF_W){1'b0}}, cur.off};
        end else begin
            res.access_address = cur.base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
            r_busy      <= (rem != 7'd0);
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
            r_job <= n_job;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_rsp   = r_out;

endmodule

`default_nettype wire

/* rtl/pci_config_access_splitter_core.sv */
// pci_config_access_splitter_core: top level of the configuration access splitter
// depends on pcas_pkg, pcas_front, pcas_fifo, pcas_back
//
//  channel   | direction | handshake                  | word
//  ----------+-----------+----------------------------+------------------------------
//  request   | in        | push / full                | i_req  (t_req)
//  result    | out       | empty / pop                | o_rsp  (t_rsp)
//  config    | in        | i_cfg_we, i_cfg_index      | i_cfg_wdata (32 bits)
//
//  the back-end sequencer emits one access word per cycle while its output register is free or
//  popped; a request splits into at most 18 accesses, for 64 bytes at an odd offset
//  a two-entry job queue lets the next requests be accepted meanwhile
//  a held result (pop low) stalls only the sequencer; the front stalls when
//  the job queue is full
//  synchronous active-low reset clears config registers, queue and output
`default_nettype none

module pci_config_access_splitter_core
    import pcas_pkg::*;
#(
    parameter int MAX_BYTES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_wdata,
    // request side
    input  wire logic        push,
    output logic             full,
    input  wire t_req        i_req,
    // result side
    output logic             empty,
    input  wire logic        pop,
    output t_rsp             o_rsp
);

    logic    job_we;
    t_job    job_in;
    t_job    job_head;
    logic    job_pop;
    t_q_stat q_stat;

    // request accepted when queue has room
    assign full = q_stat.full;

    // front: config registers, window decode, zero-count drop
    pcas_front #(
        .MAX_BYTES (MAX_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_take      (push && !q_stat.full),
        .i_req       (i_req),
        .o_job_we    (job_we),
        .o_job       (job_in)
    );

    // classified jobs waiting for the sequencer
    pcas_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (job_we),
        .i_job   (job_in),
        .i_re    (job_pop),
        .o_job   (job_head),
        .o_stat  (q_stat)
    );

    // back: one access word per cycle into the output register while it is free or popped
    pcas_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (job_head),
        .i_q_empty (q_stat.empty),
        .o_q_pop   (job_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_rsp     (o_rsp)
    );

endmodule

`default_nettype wire

/* bench/pci_config_access_splitter_core_test.sv */
// self-checking bench for pci_config_access_splitter_core: directed table, then random phases
// predicts untyped access words in-bench from the register copies; depends on pcas_pkg and the rtl
`timescale 1ns / 1ps

module pci_config_access_splitter_core_test;
    import pcas_pkg::*;

    localparam int MAX_BYTES   = 64;
    localparam int CYCLE_LIMIT = 400000;
    // cycles to wait after the last owed word before a register load
    localparam int SETTLE      = 24;
    localparam int IDLE_PCT    = 13;

    localparam logic       RD = 1'b0;
    localparam logic       WR = 1'b1;
    localparam logic [1:0] KIND_SINGLE = 2'd1;
    localparam logic [1:0] KIND_SPLIT  = 2'd2;

    // one directed row: register setting, request, and optionally a typed-in word
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] base0;
        logic [31:0] basen;
        t_req        req;
        logic        typed;
        t_rsp        word;
    } t_row;

    localparam int NROWS = 20;
    localparam t_row PLAN [0:NROWS-1] = '{
        // after reset: no bridge, one word whatever the count
        '{BRIDGE_NONE, 32'h0, 32'h0, '{RD, 8'd0, 5'd0, 3'd0, 8'h00, 7'd4}, 1'b1,
          '{32'h0, 3'd0, RD, ST_NO_BRIDGE, 1'b1}},
        '{BRIDGE_NONE, 32'h0, 32'h0, '{WR, 8'd255, 5'd31, 3'd7, 8'hff, 7'd0}, 1'b1,
          '{32'h0, 3'd0, WR, ST_NO_BRIDGE, 1'b1}},
        // single-window bridge
        '{KIND_SINGLE, 32'h8000_0000, 32'h4000_0000, '{RD, 8'd0, 5'd0, 3'd0, 8'h00, 7'd4},
          1'b1, '{32'h8001_0000, 3'd4, RD, ST_OK, 1'b1}},
        '{KIND_SINGLE, 32'h8000_0000, 32'h4000_0000, '{WR, 8'd0, 5'd3, 3'd7, 8'hff, 7'd64},
          1'b0, '0},
        '{KIND_SINGLE, 32'h8000_0000, 32'h4000_0000, '{RD, 8'd0, 5'd4, 3'd2, 8'h10, 7'd5},
          1'b0, '0},
        '{KIND_SINGLE, 32'h8000_0000, 32'h4000_0000, '{WR, 8'd0, 5'd31, 3'd0, 8'h00, 7'd3},
          1'b0, '0},
        '{KIND_SINGLE, 32'h8000_0000, 32'h4000_0000, '{RD, 8'd15, 5'd31, 3'd7, 8'h01, 7'd127},
          1'b0, '0},
        '{KIND_SINGLE, 32'h8000_0000, 32'h4000_0000, '{WR, 8'd16, 5'd0, 3'd0, 8'h00, 7'd1},
          1'b1, '{32'h0, 3'd1, WR, ST_UNREACH, 1'b1}},
        '{KIND_SINGLE, 32'h8000_0000, 32'h4000_0000, '{RD, 8'd255, 5'd0, 3'd0, 8'h02, 7'd2},
          1'b1, '{32'h0, 3'd2, RD, ST_UNREACH, 1'b1}},
        '{KIND_SINGLE, 32'h8000_0000, 32'h4000_0000, '{RD, 8'd1, 5'd0, 3'd0, 8'h00, 7'd0},
          1'b0, '0},
        '{KIND_SINGLE, 32'h8000_0000, 32'h4000_0000, '{RD, 8'd1, 5'd1, 3'd1, 8'h00, 7'd3},
          1'b0, '0},
        '{KIND_SINGLE, 32'h8000_0000, 32'h4000_0000, '{WR, 8'd2, 5'd2, 3'd2, 8'h21, 7'd2},
          1'b0, '0},
        // four-slot bridge, bases at the top so addresses wrap
        '{BRIDGE_FOUR_SLOT, 32'hffff_ffff, 32'hffff_0000, '{RD, 8'd0, 5'd4, 3'd5, 8'h10, 7'd8},
          1'b0, '0},
        '{BRIDGE_FOUR_SLOT, 32'hffff_ffff, 32'hffff_0000, '{WR, 8'd0, 5'd2, 3'd0, 8'hff, 7'd64},
          1'b0, '0},
        '{BRIDGE_FOUR_SLOT, 32'hffff_ffff, 32'hffff_0000, '{RD, 8'd1, 5'd31, 3'd7, 8'hfe, 7'd100},
          1'b0, '0},
        '{BRIDGE_FOUR_SLOT, 32'hffff_ffff, 32'hffff_0000, '{WR, 8'd0, 5'd5, 3'd3, 8'h00, 7'd4},
          1'b0, '0},
        // split-window bridge, bus 0 window absent
        '{KIND_SPLIT, 32'h0, 32'h1234_5678, '{RD, 8'd0, 5'd0, 3'd0, 8'h00, 7'd4},
          1'b1, '{32'h0, 3'd4, RD, ST_UNREACH, 1'b1}},
        '{KIND_SPLIT, 32'h0, 32'h1234_5678, '{WR, 8'd7, 5'd9, 3'd3, 8'h41, 7'd9},
          1'b0, '0},
        // upper-bus window absent
        '{KIND_SINGLE, 32'h0001_0000, 32'h0, '{WR, 8'd1, 5'd0, 3'd0, 8'h00, 7'd4},
          1'b1, '{32'h0, 3'd4, WR, ST_UNREACH, 1'b1}},
        '{KIND_SINGLE, 32'h0001_0000, 32'h0, '{RD, 8'd0, 5'd1, 3'd0, 8'h00, 7'd2},
          1'b1, '{32'h0003_0000, 3'd2, RD, ST_OK, 1'b1}}
    };

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_index = CFG_BRIDGE_KIND;
    logic [31:0] i_cfg_wdata = '0;
    logic        push        = 1'b0;
    logic        full;
    t_req        i_req       = '0;
    logic        empty;
    logic        pop         = 1'b0;
    t_rsp        o_rsp;

    // bench copy of the configuration registers
    logic [1:0]  kind_copy  = BRIDGE_NONE;
    logic [31:0] base0_copy = '0;
    logic [31:0] basen_copy = '0;

    t_rsp access_q [$];      // access words still owed by the block
    int   mismatches = 0;
    int   cycles     = 0;
    bit   calm       = 1'b0; // both sides run without gaps while set

    pci_config_access_splitter_core #(.MAX_BYTES(MAX_BYTES)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .full        (full),
        .i_req       (i_req),
        .empty       (empty),
        .pop         (pop),
        .o_rsp       (o_rsp)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // cut one request into access words and queue them up
    task automatic split_request(input t_req r);
        logic [6:0]  left;
        logic [8:0]  off;
        logic [2:0]  len;
        logic [31:0] addr;
        t_status     st;
        t_rsp        w;
        if (kind_copy == BRIDGE_NONE) begin
            w = '{access_address: '0, access_size: '0, is_write: r.command,
                  status: ST_NO_BRIDGE, last: 1'b1};
            access_q.push_back(w);
            return;
        end
        // counts past the limit are clipped
        left = (r.byte_count > MAX_BYTES) ? 7'(MAX_BYTES) : r.byte_count;
        off  = {1'b0, r.start_offset};
        while (left != 0) begin
            // odd offset first, then full dwords, then a three-byte tail as two bytes and one
            if (off[0])
                len = 3'd1;
            else if (left == 7'd3)
                len = 3'd2;
            else if (left > 7'd4)
                len = 3'd4;
            else
                len = left[2:0];
            st   = ST_OK;
            addr = '0;
            if (r.bus == 8'd0) begin
                if (base0_copy == '0)
                    st = ST_UNREACH;
                else if (r.device <= LAST_SLOT)
                    addr = base0_copy + (SLOT_STRIDE << r.device)
                         + {r.function_req, 8'h00} + off;
                else if (r.device == SLOT4 && kind_copy == BRIDGE_FOUR_SLOT)
                    addr = base0_copy + SLOT4_WINDOW + {r.function_req, 8'h00} + off;
                else
                    addr = base0_copy;   // no slot selected, bare base
            end else if (basen_copy == '0 || r.bus > LAST_BUS) begin
                st = ST_UNREACH;
            end else begin
                addr = basen_copy + {r.bus, 16'h0000} + {r.device, 11'h000}
                     + {r.function_req, 8'h00} + off;
            end
            left = left - 7'(len);
            off  = off + 9'(len);
            w = '{access_address: addr, access_size: len, is_write: r.command,
                  status: st, last: (left == 0)};
            access_q.push_back(w);
        end
    endtask

    // hand one request to the block; returns once it has been taken
    task automatic send_request(input t_req r, input logic typed, input t_rsp word);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push  <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (full);
        if (typed)
            access_q.push_back(word);
        else
            split_request(r);
    endtask

    // wait until the block is quiet, then load all three registers
    task automatic load_registers(input logic [1:0] kind, input logic [31:0] b0,
                                  input logic [31:0] bn);
        @(negedge i_clk);
        push <= 1'b0;
        while (access_q.size() != 0)
            @(posedge i_clk);
        // zero-count requests with a bridge never reach the job queue; this wait is only a margin
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_BRIDGE_KIND;
        i_cfg_wdata <= {30'h0, kind};
        @(negedge i_clk);
        i_cfg_index <= CFG_BUS0_BASE;
        i_cfg_wdata <= b0;
        @(negedge i_clk);
        i_cfg_index <= CFG_BUSN_BASE;
        i_cfg_wdata <= bn;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        kind_copy  = kind;
        base0_copy = b0;
        basen_copy = bn;
    endtask

    function automatic logic [31:0] pick_base();
        case ($urandom_range(5))
            0:       return 32'h0;
            1:       return 32'hffff_ffff;
            2:       return $urandom() & 32'hffff_0000;
            default: return $urandom();
        endcase
    endfunction

    // random request, weighted toward the decoded slots and the lower buses
    function automatic t_req pick_request();
        t_req r;
        int   dice;
        r.command      = 1'($urandom_range(1));
        dice           = $urandom_range(9);
        r.bus          = (dice < 4) ? 8'd0 :
                         (dice < 8) ? 8'($urandom_range(15, 1)) : 8'($urandom_range(255, 16));
        r.device       = ($urandom_range(3) == 0) ? 5'($urandom_range(31))
                                                  : 5'($urandom_range(5));
        r.function_req = 3'($urandom_range(7));
        r.start_offset = 8'($urandom_range(255));
        dice           = $urandom_range(99);
        r.byte_count   = (dice < 4)  ? 7'd0 :
                         (dice < 12) ? 7'($urandom_range(127, 65)) :
                         (dice < 40) ? 7'($urandom_range(8, 1)) : 7'($urandom_range(64, 1));
        return r;
    endfunction

    // result side: random stalls except in the calm stretch
    always @(negedge i_clk) begin
        pop <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // compare every accepted word with the oldest one owed
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (access_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: addr=%h size=%0d wr=%0b st=%0d last=%0b",
                             o_rsp.access_address, o_rsp.access_size, o_rsp.is_write,
                             o_rsp.status, o_rsp.last);
            end else begin
                if (o_rsp.access_address !== access_q[0].access_address ||
                    o_rsp.access_size    !== access_q[0].access_size    ||
                    o_rsp.is_write       !== access_q[0].is_write       ||
                    o_rsp.status         !== access_q[0].status         ||
                    o_rsp.last           !== access_q[0].last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word mismatch: exp addr=%h size=%0d wr=%0b st=%0d last=%0b",
                                 access_q[0].access_address, access_q[0].access_size,
                                 access_q[0].is_write, access_q[0].status, access_q[0].last,
                                 " got addr=%h size=%0d wr=%0b st=%0d last=%0b",
                                 o_rsp.access_address, o_rsp.access_size, o_rsp.is_write,
                                 o_rsp.status, o_rsp.last);
                end
                void'(access_q.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("pci_config_access_splitter_core_test: done, errors");
            $finish;
        end
    end

    initial begin
        logic [1:0] kind;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table; registers reloaded only when a row asks for new ones
        for (int i = 0; i < NROWS; i++) begin
            if (PLAN[i].kind != kind_copy || PLAN[i].base0 != base0_copy ||
                PLAN[i].basen != basen_copy)
                load_registers(PLAN[i].kind, PLAN[i].base0, PLAN[i].basen);
            send_request(PLAN[i].req, PLAN[i].typed, PLAN[i].word);
        end

        // random phases, each under its own register setting
        for (int p = 0; p < 8; p++) begin
            kind = (p == 0) ? BRIDGE_FOUR_SLOT :
                   (p == 5) ? BRIDGE_NONE :
                   ($urandom_range(9) == 0) ? BRIDGE_NONE : 2'($urandom_range(3, 1));
            load_registers(kind, pick_base(), pick_base());
            calm = (p == 3);
            for (int k = 0; k < 58; k++)
                send_request(pick_request(), 1'b0, '0);
            calm = 1'b0;
        end

        @(negedge i_clk);
        push <= 1'b0;
        while (access_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && access_q.size() == 0)
            $display("pci_config_access_splitter_core_test: done, clean");
        else
            $display("pci_config_access_splitter_core_test: done, errors");
        $finish;
    end

endmodule
